@@ src/lru_key_value_cache_assert.svh @@
// Assertion macros shared by the checkers of the LRU key-value cache.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define LKV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru_key_value_cache: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define LKV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru_key_value_cache: same-cycle check failed");

`endif

@@ src/lkv_pkg.sv @@
// Package of the LRU key-value cache: widths, reset values, codes and the
// structs passed between the top level and the cell row. No dependencies.
`default_nettype none

package lkv_pkg;

  localparam int CAPACITY_DEF = 8;
  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;
  localparam int CFG_W        = 4;

  localparam logic [CFG_W-1:0] CAP_RESET = 4'd8;

  typedef enum logic {
    REQ_GET = 1'b0,
    REQ_PUT = 1'b1
  } lkv_req_t;

  // One stored entry; position in the row is its recency (0 is most recent).
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lkv_entry_t;

  // Row-wide control for the cycle in which a word is accepted.
  typedef struct packed {
    logic hit_op;  // accepted request matched a stored key
    logic ins;     // accepted put with a new key
    logic full;    // occupancy has reached the capacity in use
  } lkv_ctl_t;

endpackage

`default_nettype wire

@@ src/lkv_cell.sv @@
// One cell of the recency-ordered entry row of the LRU key-value cache.
// Depends on lkv_pkg for the entry and control structs.
`default_nettype none

module lkv_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  lkv_pkg::lkv_ctl_t        ctl,
  input  lkv_pkg::lkv_entry_t      prev,
  input  logic [lkv_pkg::KEY_W-1:0] key,
  input  logic                     hit_tail_in,
  input  logic [lkv_pkg::VAL_W-1:0] rd_in,
  output lkv_pkg::lkv_entry_t      entry,
  output logic                     hit_tail_out,
  output logic [lkv_pkg::VAL_W-1:0] rd_out
);
  import lkv_pkg::*;

  logic hit;
  logic shift;

  assign hit          = entry.valid && (entry.key == key);
  assign hit_tail_out = hit | hit_tail_in;
  assign rd_out       = rd_in | (hit ? entry.value : '0);

  // On a hit every cell from the front up to the matching one moves back by
  // one. On an insert the row moves back over the valid cells; when full the
  // last valid cell is overwritten, otherwise the first free cell is filled.
  always_comb begin
    if (ctl.hit_op) begin
      shift = hit_tail_out;
    end else if (ctl.ins) begin
      shift = ctl.full ? entry.valid : prev.valid;
    end else begin
      shift = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (shift) begin
      entry <= prev;
    end
  end

endmodule

`default_nettype wire

@@ src/lru_key_value_cache.sv @@
// Top level of the fully associative LRU key-value cache.
// Depends on lkv_pkg and lkv_cell.
//
// Usage:
//   Requests come in on the s_ stream: s_tuser is the request kind (get or
//   put), s_tdata carries key and value. Every request gives exactly one
//   word on the m_ stream: m_tuser is the found flag, m_tdata the value read
//   on a get hit and zero otherwise.
//   The key of a request is compared against every cell at once and the
//   recency row shifts at the accepting edge, so the result is valid the
//   cycle after acceptance and a new request can be taken every cycle while
//   the output register is empty or being drained.
//   The output register holds its word while m_tready is low; s_tready is
//   high whenever that register is empty or being drained in the same cycle,
//   so a stalled receiver holds off the sender after one word.
//   cfg_we/cfg_data write the capacity in use; 0 acts as 1 and values above
//   CAPACITY act as CAPACITY. Lowering it evicts nothing until later puts.
//   Reset empties the cache, sets the capacity in use to 8 and drops any
//   pending result.
`default_nettype none

module lru_key_value_cache #(
  parameter int CAPACITY = lkv_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lkv_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [31:0] key, [63:32] value
  input  logic [lkv_pkg::KEY_W+lkv_pkg::VAL_W-1:0] s_tdata,
  // [0] req_type
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [31:0] read_value
  output logic [lkv_pkg::VAL_W-1:0]           m_tdata,
  // [0] found
  output logic                                m_tuser
);
  import lkv_pkg::*;

  localparam int OW = $clog2(CAPACITY + 1);
  localparam int CW = (OW > CFG_W) ? OW : CFG_W;
  localparam logic [CW-1:0] CAP_MAX = CW'(CAPACITY);

  logic [CFG_W-1:0] cap;
  logic [CW-1:0]    cap_ext;
  logic [CW-1:0]    cap_eff;
  logic [OW-1:0]    occ;
  logic [OW-1:0]    occ_next;
  logic             full;
  logic             accept;
  logic             hit_any;
  lkv_req_t         req;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_value;
  lkv_ctl_t         ctl;
  lkv_entry_t       front_entry;
  lkv_entry_t       entries [CAPACITY];
  logic             hit_tail [CAPACITY+1];
  logic [VAL_W-1:0] rd [CAPACITY+1];
  logic             out_valid;
  logic             out_found;
  logic [VAL_W-1:0] out_rdata;

  assign req      = lkv_req_t'(s_tuser);
  assign in_key   = s_tdata[KEY_W-1:0];
  assign in_value = s_tdata[KEY_W+VAL_W-1:KEY_W];

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_data;
    end
  end

  always_comb begin
    cap_ext = CW'(cap);
    if (cap == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign full    = CW'(occ) >= cap_eff;
  assign hit_any = hit_tail[0];

  assign ctl.hit_op = accept && hit_any;
  assign ctl.ins    = accept && !hit_any && (req == REQ_PUT);
  assign ctl.full   = full;

  // Whatever enters the front cell becomes the most recent entry.
  assign front_entry.valid = 1'b1;
  assign front_entry.key   = in_key;
  assign front_entry.value = (req == REQ_PUT) ? in_value : rd[0];

  assign hit_tail[CAPACITY] = 1'b0;
  assign rd[CAPACITY]       = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lkv_entry_t prev;
    if (i == 0) begin : g_front
      assign prev = front_entry;
    end else begin : g_rest
      assign prev = entries[i-1];
    end
    lkv_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .prev         (prev),
      .key          (in_key),
      .hit_tail_in  (hit_tail[i+1]),
      .rd_in        (rd[i+1]),
      .entry        (entries[i]),
      .hit_tail_out (hit_tail[i]),
      .rd_out       (rd[i])
    );
  end

  always_comb begin
    occ_next = occ;
    if (ctl.ins && !full) begin
      occ_next = occ + OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_found <= hit_any;
      out_rdata <= (hit_any && (req == REQ_GET)) ? rd[0] : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_rdata;
  assign m_tuser  = out_found;

endmodule

`default_nettype wire

@@ src/lkv_checker.sv @@
// Port-level checker for the LRU key-value cache, bound to the top level.
// Depends on lru_key_value_cache_assert.svh for the assertion macros.
`default_nettype none

`include "lru_key_value_cache_assert.svh"

module lkv_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // A word waiting at the output stays until it is taken.
  `LKV_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Every accepted request shows its result in the next cycle.
  `LKV_ASSERT_NEXT(a_one_cycle, clk, rst, s_tvalid && s_tready, m_tvalid)

  // A drained output with no new request leaves nothing behind.
  `LKV_ASSERT_NEXT(a_no_extra, clk, rst, m_tvalid && m_tready && !(s_tvalid && s_tready), !m_tvalid)

  // A miss never returns data.
  `LKV_ASSERT_NOW(a_miss_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == 32'd0)

  // Reset drops any pending result.
  `LKV_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid)

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/sv/lru_key_value_cache_tb.sv @@
// Self-checking testbench for the LRU key-value cache, driven over its request stream.
// Depends on lkv_pkg and lru_key_value_cache, which in turn depends on lkv_cell.
module lru_key_value_cache_tb;
  import lkv_pkg::*;

  localparam int SLOTS = CAPACITY_DEF;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
  } lookup_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_W-1:0]       cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [KEY_W+VAL_W-1:0] s_tdata;   // [31:0] key, [63:32] value
  logic                   s_tuser;   // [0] req_type
  logic                   m_tvalid;
  logic                   m_tready;
  logic [VAL_W-1:0]       m_tdata;   // [31:0] read_value
  logic                   m_tuser;   // [0] found

  lru_key_value_cache dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Shadow copy of the cache contents; age 0 is the most recent entry.
  logic             slot_used [SLOTS];
  logic [KEY_W-1:0] slot_key  [SLOTS];
  logic [VAL_W-1:0] slot_val  [SLOTS];
  int unsigned      slot_age  [SLOTS];
  int unsigned      fill_count;
  logic [CFG_W-1:0] cap_setting;

  lookup_result_t pending_results[$];
  logic [KEY_W-1:0] key_pool[16];
  int pool_size;

  int errors;
  int requests_sent;
  int hit_count;
  int eviction_count;
  int cap_writes;
  bit no_idle;
  int rx_hold;
  int rx_stall;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void make_recent(int s, int unsigned old_age);
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && i != s && slot_age[i] < old_age) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  // Applies one request to the shadow cache and returns the word it must produce.
  function automatic lookup_result_t lru_predict(lkv_req_t kind, logic [KEY_W-1:0] k,
                                                  logic [VAL_W-1:0] v);
    lookup_result_t res;
    int unsigned limit;
    int unsigned worst;
    int s;
    bit hit;
    res = '0;
    hit = 1'b0;
    s = 0;
    worst = 0;
    limit = (cap_setting == 0) ? 1 : (cap_setting > SLOTS) ? SLOTS : cap_setting;
    for (int i = 0; i < SLOTS; i++) begin
      if (!hit && slot_used[i] && slot_key[i] == k) begin
        hit = 1'b1;
        s = i;
      end
    end
    if (hit) begin
      res.found = 1'b1;
      hit_count++;
      if (kind == REQ_PUT) slot_val[s] = v;
      else res.read_value = slot_val[s];
      make_recent(s, slot_age[s]);
    end else if (kind == REQ_PUT) begin
      if (fill_count < limit) begin
        s = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (s < 0 && !slot_used[i]) s = i;
        end
        fill_count++;
        worst = SLOTS;
      end else begin
        // Full for the capacity in use: the oldest valid entry is replaced.
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && slot_age[i] >= worst) begin
            worst = slot_age[i];
            s = i;
          end
        end
        eviction_count++;
      end
      slot_used[s] = 1'b1;
      slot_key[s] = k;
      slot_val[s] = v;
      make_recent(s, worst);
    end
    return res;
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected word: found=%0b read_value=%h", m_tuser, m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.found || m_tdata !== want.read_value)
          note_failure($sformatf("mismatch: expected found=%0b read_value=%h, got found=%0b read_value=%h",
                                 want.found, want.read_value, m_tuser, m_tdata));
      end
    end
  end

  // Receiver: a requested long hold-off wins over the random stalls.
  initial begin
    m_tready = 1'b0;
    rx_stall = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready = 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        m_tready = 1'b0;
        rx_stall--;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        m_tready = 1'b0;
        rx_stall = pick_gap();
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic send_request(input lkv_req_t kind, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = kind;
    s_tdata = {v, k};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(lru_predict(kind, k, v));
    requests_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] c);
    wait_drained();
    repeat (3) @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = c;
    @(posedge clk);
    cap_setting = c;
    cap_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, pool_size - 1)];
    return $urandom();
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'h8000_0000;
    if (r < 6) return 32'h7fff_ffff;
    return $urandom();
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_request($urandom_range(0, 1) ? REQ_PUT : REQ_GET, pick_key(), pick_value());
  endtask

  task automatic test_basic_ops();
    send_request(REQ_GET, 32'h0000_0000, 32'hffff_ffff);
    send_request(REQ_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_request(REQ_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_request(REQ_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_request(REQ_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(REQ_GET, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_GET, 32'hffff_ffff, 32'h0000_0000);
    send_request(REQ_PUT, 32'h0000_0000, 32'h1234_5678);
    send_request(REQ_GET, 32'h5555_5555, 32'haaaa_aaaa);
  endtask

  // Four new keys fill the cache; the fifth pushes out the oldest entry.
  task automatic test_eviction();
    for (int i = 1; i <= 5; i++) send_request(REQ_PUT, i, 32'hc0de_0000 + i);
    send_request(REQ_GET, 32'h8000_0000, 32'h0000_0000);
  endtask

  // Capacity zero acts as one while eight entries are resident from before, so each new key evicts the oldest.
  task automatic test_capacity_limits();
    set_capacity(4'd0);
    send_request(REQ_PUT, 32'h0000_0010, 32'h0bad_f00d);
    send_request(REQ_PUT, 32'h0000_0011, 32'hf00d_0bad);
    send_request(REQ_GET, 32'h0000_0010, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0011, 32'h0000_0000);
    send_request(REQ_GET, 32'h0000_0005, 32'h0000_0000);
  endtask

  task automatic test_random_traffic(input logic [CFG_W-1:0] c, input int n);
    int unsigned limit;
    set_capacity(c);
    limit = (c == 0) ? 1 : (c > SLOTS) ? SLOTS : c;
    pool_size = limit + 3;
    send_random(n);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_traffic(4'd6, 120);
    no_idle = 1'b0;
  endtask

  // The receiver stops for a long stretch while the sender keeps offering words.
  task automatic test_receiver_hold();
    set_capacity(4'd8);
    pool_size = 11;
    rx_hold = 150;
    send_random(80);
  endtask

  task automatic test_sender_pause();
    pool_size = 8;
    send_random(40);
    wait_drained();
    send_random(40);
  endtask

  initial begin
    logic [CFG_W-1:0] caps[10];
    int waited;
    caps = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd5, 4'd0, 4'd2, 4'd8, 4'd7, 4'd4};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    rx_hold = 0;
    no_idle = 1'b0;
    errors = 0;
    requests_sent = 0;
    hit_count = 0;
    eviction_count = 0;
    cap_writes = 0;
    fill_count = 0;
    cap_setting = CAP_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_val[i] = '0;
      slot_age[i] = 0;
    end
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;
    key_pool[4] = 32'haaaa_aaaa;
    key_pool[5] = 32'h5555_5555;
    for (int i = 6; i < 16; i++) key_pool[i] = $urandom();
    pool_size = 16;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_ops();
    test_eviction();
    test_capacity_limits();
    foreach (caps[i]) test_random_traffic(caps[i], 155);
    test_back_to_back();
    test_receiver_hold();
    test_sender_pause();

    @(negedge clk);
    s_tvalid = 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d expected words never arrived", pending_results.size()));

    $display("summary: %0d requests, %0d hits, %0d evictions, %0d capacity writes",
             requests_sent, hit_count, eviction_count, cap_writes);
    $display("summary: %0d mismatches or missing words", errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
